/* src/knn_pkg.sv */
// ----------------------------------------------------------------------------
// knn_pkg
// Shared widths, defaults and types for the top-k neighbour vote block.
// ----------------------------------------------------------------------------
`default_nettype none

package knn_pkg;

    localparam int DIST_W          = 32;
    localparam int LABEL_W         = 3;
    localparam int KCFG_W          = 4;
    localparam int COUNT_W         = 4;
    localparam int KCMP_W          = 6;
    localparam int CLS_CMP_W       = 9;
    localparam int K_MAX_DEF       = 8;
    localparam int NUM_CLASSES_DEF = 8;
    localparam int COUNT_SAT       = 15;

    localparam logic [KCFG_W-1:0] K_USED_RESET = 4'd3;

    typedef struct packed {
        logic               valid;
        logic [DIST_W-1:0]  distance;
        logic [LABEL_W-1:0] label;
        logic               keep;
    } t_slot;

    typedef struct packed {
        logic               valid;
        logic [LABEL_W-1:0] label;
    } t_post;

endpackage

`default_nettype wire

/* src/knn_cell.sv */
// ----------------------------------------------------------------------------
// knn_cell
// One slot of the sorted neighbour list: hold, take the new pair or take the
// left neighbour's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_cell import knn_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_clear,
    input  logic [DIST_W-1:0]  i_distance,
    input  logic [LABEL_W-1:0] i_label,
    input  t_slot              i_prev,
    output t_slot              o_slot,
    output t_post              o_post
);

    logic               r_valid;
    logic [DIST_W-1:0]  r_distance;
    logic [LABEL_W-1:0] r_label;

    logic               n_valid;
    logic [DIST_W-1:0]  n_distance;
    logic [LABEL_W-1:0] n_label;
    logic               keep;

    assign keep = r_valid && (r_distance <= i_distance);

    always_comb begin
        if (keep) begin
            n_valid    = r_valid;
            n_distance = r_distance;
            n_label    = r_label;
        end else if (i_prev.keep) begin
            n_valid    = 1'b1;
            n_distance = i_distance;
            n_label    = i_label;
        end else begin
            n_valid    = i_prev.valid;
            n_distance = i_prev.distance;
            n_label    = i_prev.label;
        end
    end

    assign o_slot = '{valid: r_valid, distance: r_distance, label: r_label, keep: keep};
    assign o_post = '{valid: n_valid, label: n_label};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_clear ? 1'b0 : n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_distance <= n_distance;
            r_label    <= n_label;
        end
    end

endmodule

`default_nettype wire

/* src/knn_vote.sv */
// ----------------------------------------------------------------------------
// knn_vote
// Three-stage vote pipeline: snapshot, per-slot label count, winner tree and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_vote import knn_pkg::*; #(
    parameter int K_MAX = K_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [K_MAX-1:0]   i_en,
    input  logic [LABEL_W-1:0] i_lab [K_MAX],
    input  logic               i_out_stall,
    output logic               o_busy,
    output logic               o_out_valid,
    output logic [LABEL_W-1:0] o_predicted_label,
    output logic [COUNT_W-1:0] o_vote_count
);

    localparam int CNT_W = $clog2(K_MAX + 1);
    localparam int LV    = $clog2(K_MAX);
    localparam int P     = 1 << LV;
    localparam logic [KCMP_W-1:0] SAT = KCMP_W'(COUNT_SAT);

    logic               r_s1_valid;
    logic [K_MAX-1:0]   r_s1_en;
    logic [LABEL_W-1:0] r_s1_lab [K_MAX];

    logic               r_s2_valid;
    logic [CNT_W-1:0]   r_s2_cnt [K_MAX];
    logic [LABEL_W-1:0] r_s2_lab [K_MAX];

    logic               r_s3_valid;
    logic [LABEL_W-1:0] r_s3_label;
    logic [COUNT_W-1:0] r_s3_count;

    logic [CNT_W-1:0]   n_s2_cnt [K_MAX];
    logic [LABEL_W-1:0] n_s2_lab [K_MAX];
    logic [CNT_W-1:0]   tc [LV+1][P];
    logic [LABEL_W-1:0] tl [LV+1][P];
    logic [KCMP_W-1:0]  win_cnt;

    logic adv1, adv2, adv3;

    assign adv3   = !r_s3_valid || !i_out_stall;
    assign adv2   = !r_s2_valid || adv3;
    assign adv1   = !r_s1_valid || adv2;
    assign o_busy = !adv1;

    always_comb begin
        for (int j = 0; j < K_MAX; j++) begin
            n_s2_cnt[j] = '0;
            for (int i = 0; i < K_MAX; i++) begin
                n_s2_cnt[j] = n_s2_cnt[j] + CNT_W'(r_s1_en[i] && r_s1_en[j]
                                                   && (r_s1_lab[i] == r_s1_lab[j]));
            end
            n_s2_lab[j] = r_s1_en[j] ? r_s1_lab[j] : '0;
        end
    end

    always_comb begin
        for (int l = 0; l <= LV; l++) begin
            for (int e = 0; e < P; e++) begin
                tc[l][e] = '0;
                tl[l][e] = '0;
            end
        end
        for (int e = 0; e < K_MAX; e++) begin
            tc[0][e] = r_s2_cnt[e];
            tl[0][e] = r_s2_lab[e];
        end
        for (int l = 0; l < LV; l++) begin
            for (int e = 0; e < (P >> (l + 1)); e++) begin
                if ((tc[l][2*e] > tc[l][2*e+1]) ||
                    ((tc[l][2*e] == tc[l][2*e+1]) && (tl[l][2*e] <= tl[l][2*e+1]))) begin
                    tc[l+1][e] = tc[l][2*e];
                    tl[l+1][e] = tl[l][2*e];
                end else begin
                    tc[l+1][e] = tc[l][2*e+1];
                    tl[l+1][e] = tl[l][2*e+1];
                end
            end
        end
    end

    assign win_cnt = KCMP_W'(tc[LV][0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (adv1) begin
                r_s1_valid <= i_take;
            end
            if (adv2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (adv3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_take) begin
            r_s1_en  <= i_en;
            r_s1_lab <= i_lab;
        end
        if (adv2 && r_s1_valid) begin
            r_s2_cnt <= n_s2_cnt;
            r_s2_lab <= n_s2_lab;
        end
        if (adv3 && r_s2_valid) begin
            r_s3_label <= tl[LV][0];
            r_s3_count <= (win_cnt > SAT) ? COUNT_W'(COUNT_SAT) : win_cnt[COUNT_W-1:0];
        end
    end

    assign o_out_valid       = r_s3_valid;
    assign o_predicted_label = r_s3_label;
    assign o_vote_count      = r_s3_count;

endmodule

`default_nettype wire

/* src/knn_topk_vote.sv */
// A beat marked last has its result registered in the vote pipeline's
//   snapshot, count and winner/output stages; an output stall holds it.
// Throughput: one input beat a cycle while not stalled; the cell row inserts
//   each pair in its accept cycle and clears on the last beat of a query.
// Reset (synchronous, active low) empties the list, drains the vote pipeline
//   and sets k_used to 3.
// ----------------------------------------------------------------------------
// knn_topk_vote
// Top-k nearest neighbour selection over a row of compare-insert cells with a
// majority vote on the final beat of each query.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_topk_vote import knn_pkg::*; #(
    parameter int K_MAX       = K_MAX_DEF,
    parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [DIST_W-1:0]  i_distance,
    input  logic [LABEL_W-1:0] i_label,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [LABEL_W-1:0] o_predicted_label,
    output logic [COUNT_W-1:0] o_vote_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [KCFG_W-1:0]  i_cfg_data
);

    logic [KCFG_W-1:0]  r_k_used;
    logic [KCMP_W-1:0]  k_eff;
    logic               accept;
    logic               busy;
    t_slot              chain [K_MAX+1];
    t_post              post  [K_MAX];
    logic [K_MAX-1:0]   vote_en;
    logic [LABEL_W-1:0] vote_lab [K_MAX];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = busy;
    assign accept      = i_in_valid && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_used <= K_USED_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_k_used <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_k_used == '0) begin
            k_eff = KCMP_W'(1);
        end else if (KCMP_W'(r_k_used) > KCMP_W'(K_MAX)) begin
            k_eff = KCMP_W'(K_MAX);
        end else begin
            k_eff = KCMP_W'(r_k_used);
        end
    end

    assign chain[0] = '{valid: 1'b0, distance: '0, label: '0, keep: 1'b1};

    for (genvar g = 0; g < K_MAX; g++) begin : g_cell
        knn_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (accept),
            .i_clear    (i_last),
            .i_distance (i_distance),
            .i_label    (i_label),
            .i_prev     (chain[g]),
            .o_slot     (chain[g+1]),
            .o_post     (post[g])
        );

        assign vote_en[g]  = post[g].valid && (KCMP_W'(g) < k_eff)
                             && (CLS_CMP_W'(post[g].label) < CLS_CMP_W'(NUM_CLASSES));
        assign vote_lab[g] = post[g].label;
    end

    knn_vote #(
        .K_MAX (K_MAX)
    ) u_vote (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_take            (accept && i_last),
        .i_en              (vote_en),
        .i_lab             (vote_lab),
        .i_out_stall       (i_out_stall),
        .o_busy            (busy),
        .o_out_valid       (o_out_valid),
        .o_predicted_label (o_predicted_label),
        .o_vote_count      (o_vote_count)
    );

endmodule

`default_nettype wire

/* src/knn_chk.sv */
// ----------------------------------------------------------------------------
// knn_chk
// Port-level checks on the vote result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_chk import knn_pkg::*; #(
    parameter int K_MAX = K_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic [LABEL_W-1:0] o_predicted_label,
    input  logic [COUNT_W-1:0] o_vote_count
);

    localparam logic [KCMP_W-1:0] CAP = (K_MAX > COUNT_SAT) ? KCMP_W'(COUNT_SAT)
                                                             : KCMP_W'(K_MAX);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_predicted_label)
                                       && $stable(o_vote_count))
        else $error("result beat changed while stalled");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> KCMP_W'(o_vote_count) <= CAP)
        else $error("vote count exceeds neighbour count");

    a_no_vote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_vote_count == '0) |-> o_predicted_label == '0)
        else $error("empty vote must give class zero");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat straight after reset");

endmodule

bind knn_topk_vote knn_chk #(
    .K_MAX (K_MAX)
) u_knn_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_predicted_label (o_predicted_label),
    .o_vote_count      (o_vote_count)
);

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the top-k neighbour vote. A clocked driver streams
// (distance, label, last) beats from a queue, a clocked monitor keeps its own
// sorted neighbour list and vote tally, and every vote result is compared
// field by field. Directed queries cover ties, extremes, a full list and
// dropped pairs; random queries run under several k settings and idle mixes.
// ----------------------------------------------------------------------------

module tb_top;
    import knn_pkg::*;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [LABEL_W-1:0] label;
        logic               last;
    } t_beat;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [COUNT_W-1:0] count;
    } t_vote;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [DIST_W-1:0]  i_distance = '0;
    logic [LABEL_W-1:0] i_label = '0;
    logic               i_last = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [LABEL_W-1:0] o_predicted_label;
    logic [COUNT_W-1:0] o_vote_count;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [KCFG_W-1:0]  i_cfg_data = K_USED_RESET;

    t_beat beat_q[$];
    t_vote vote_q[$];
    t_beat next_beat;
    t_vote got_vote;
    t_vote want_vote;
    int    send_idle_pct = 0;
    int    stall_pct = 0;
    int    err_count = 0;

    logic [DIST_W-1:0]  near_dist [K_MAX_DEF];
    logic [LABEL_W-1:0] near_lab  [K_MAX_DEF];
    logic               near_vld  [K_MAX_DEF];
    logic [KCFG_W-1:0]  k_cfg = K_USED_RESET;

    int k_plan     [8] = '{1, 8, 15, 0, 5, 2, 9, 4};
    int idle_plan  [8] = '{0, 69, 0, 17, 0, 69, 0, 17};
    int stall_plan [8] = '{0, 0, 69, 17, 0, 0, 69, 17};

    knn_topk_vote dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_distance        (i_distance),
        .i_label           (i_label),
        .i_last            (i_last),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_predicted_label (o_predicted_label),
        .o_vote_count      (o_vote_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void rank_neighbour(input logic [DIST_W-1:0] d,
                                           input logic [LABEL_W-1:0] l);
        int pos;
        pos = 0;
        while (pos < K_MAX_DEF && near_vld[pos] && near_dist[pos] <= d)
            pos++;
        if (pos < K_MAX_DEF) begin
            for (int i = K_MAX_DEF - 1; i > pos; i--) begin
                near_dist[i] = near_dist[i-1];
                near_lab[i]  = near_lab[i-1];
                near_vld[i]  = near_vld[i-1];
            end
            near_dist[pos] = d;
            near_lab[pos]  = l;
            near_vld[pos]  = 1'b1;
        end
    endfunction

    function automatic t_vote close_query();
        int    tally [NUM_CLASSES_DEF];
        int    k;
        int    top;
        t_vote res;
        k = (k_cfg == 0) ? 1 : (k_cfg > K_MAX_DEF) ? K_MAX_DEF : int'(k_cfg);
        for (int c = 0; c < NUM_CLASSES_DEF; c++)
            tally[c] = 0;
        for (int i = 0; i < k; i++)
            if (near_vld[i] && near_lab[i] < NUM_CLASSES_DEF)
                tally[near_lab[i]]++;
        top = 0;
        res.label = '0;
        for (int c = 0; c < NUM_CLASSES_DEF; c++) begin
            if (tally[c] > top) begin
                top = tally[c];
                res.label = LABEL_W'(c);
            end
        end
        res.count = (top > COUNT_SAT) ? COUNT_W'(COUNT_SAT) : COUNT_W'(top);
        for (int i = 0; i < K_MAX_DEF; i++)
            near_vld[i] = 1'b0;
        return res;
    endfunction

    function automatic void push_beat(input logic [DIST_W-1:0] d,
                                      input logic [LABEL_W-1:0] l, input logic lst);
        t_beat b;
        b.distance = d;
        b.label    = l;
        b.last     = lst;
        beat_q.push_back(b);
    endfunction

    function automatic logic [DIST_W-1:0] pick_distance();
        logic [DIST_W-1:0] d;
        case ($urandom_range(0, 3))
            0: d = DIST_W'($urandom_range(0, 15));
            1: d = $urandom_range(0, 1) ? '1 : '0;
            2: d = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: d = $urandom;
        endcase
        return d;
    endfunction

    task automatic wait_drained();
        int spin;
        spin = 0;
        while ((beat_q.size() != 0 || i_in_valid || vote_q.size() != 0) && spin < 50000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_k(input logic [KCFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // driver: advance only once the presented beat is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_beat = beat_q.pop_front();
                i_in_valid <= 1'b1;
                i_distance <= next_beat.distance;
                i_label    <= next_beat.label;
                i_last     <= next_beat.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                k_cfg = i_cfg_data;
            if (i_in_valid && !o_in_stall) begin
                rank_neighbour(i_distance, i_label);
                if (i_last)
                    vote_q.push_back(close_query());
            end
            if (o_out_valid && !i_out_stall) begin
                if (vote_q.size() == 0) begin
                    $error("unexpected result beat: predicted_label %0d vote_count %0d",
                           o_predicted_label, o_vote_count);
                    err_count++;
                end else begin
                    want_vote = vote_q.pop_front();
                    got_vote.label = o_predicted_label;
                    got_vote.count = o_vote_count;
                    if (got_vote.label !== want_vote.label) begin
                        $error("predicted_label: expected %0d, got %0d",
                               want_vote.label, got_vote.label);
                        err_count++;
                    end
                    if (got_vote.count !== want_vote.count) begin
                        $error("vote_count: expected %0d, got %0d",
                               want_vote.count, got_vote.count);
                        err_count++;
                    end
                end
            end
        end
    end

    initial begin
        int  sent;
        int  qlen;
        bit  leave_open;
        for (int i = 0; i < K_MAX_DEF; i++) begin
            near_vld[i]  = 1'b0;
            near_dist[i] = '0;
            near_lab[i]  = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // equal distances keep arrival order; single-object queries
        push_beat(32'd5, 3'd1, 1'b0);
        push_beat(32'd5, 3'd2, 1'b0);
        push_beat(32'd0, 3'd7, 1'b0);
        push_beat(32'hFFFF_FFFF, 3'd0, 1'b1);
        push_beat(32'h1234_5678, 3'd6, 1'b1);
        push_beat(32'hFFFF_FFFF, 3'd3, 1'b1);
        wait_drained();

        // fill the list, drop pairs beyond it, insert a tie on the last beat
        write_k(4'd8);
        for (int i = 0; i < K_MAX_DEF; i++)
            push_beat(DIST_W'((K_MAX_DEF - i) * 3), LABEL_W'(i), 1'b0);
        push_beat(32'd100, 3'd4, 1'b0);
        push_beat(32'hFFFF_FFFF, 3'd5, 1'b0);
        push_beat(32'd6, 3'd6, 1'b1);
        wait_drained();

        write_k(4'd0);
        push_beat(32'd7, 3'd4, 1'b0);
        push_beat(32'd2, 3'd2, 1'b1);

        for (int seg = 0; seg < 8; seg++) begin
            wait_drained();
            write_k(KCFG_W'(k_plan[seg]));
            send_idle_pct = idle_plan[seg];
            stall_pct     = stall_plan[seg];
            sent = 0;
            while (sent < 112) begin
                qlen = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24)
                                                   : $urandom_range(1, 8);
                leave_open = (sent + qlen >= 112) && ($urandom_range(0, 1) == 1);
                for (int j = 0; j < qlen; j++)
                    push_beat(pick_distance(), LABEL_W'($urandom_range(0, 7)),
                              (j == qlen - 1) && !leave_open);
                sent += qlen;
            end
        end
        push_beat(pick_distance(), LABEL_W'($urandom_range(0, 7)), 1'b1);
        wait_drained();

        if (vote_q.size() != 0) begin
            $error("%0d vote results never arrived", vote_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("PASS knn_topk_vote");
        else
            $display("FAIL knn_topk_vote");
        $finish;
    end

    initial begin
        #5000000;
        $display("FAIL knn_topk_vote");
        $finish;
    end

endmodule
